### sv/rtgs_pkg.sv
// Shared types and constants for the routing track grid snap block.
package rtgs_pkg;

   localparam int PITCH_WIDTH = 31;

   typedef enum logic [1:0] {
      ROUND_DOWN    = 2'd0,
      ROUND_UP      = 2'd1,
      ROUND_NEAREST = 2'd2,
      ROUND_UP_ALT  = 2'd3
   } round_mode_type;

   localparam logic [0:0] REG_TRACK_OFFSET = 1'b0;
   localparam logic [0:0] REG_TRACK_PITCH  = 1'b1;

endpackage

### sv/rtgs_div.sv
// Pipelined floor divider: signed dividend by positive pitch, one quotient bit per stage.
module rtgs_div #(
   parameter int DW = 51
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic signed [DW-1:0]             dividend,
   input  logic [rtgs_pkg::PITCH_WIDTH-1:0] pitch,
   output logic signed [DW-1:0]             quotient,
   output logic [rtgs_pkg::PITCH_WIDTH-1:0] remainder
);
   localparam int PW = rtgs_pkg::PITCH_WIDTH;
   localparam int RW = PW + 1;

   // Operate on magnitude; stage s retires quotient bit DW-1-s.
   logic [DW-1:0] mag_ff   [0:DW];
   logic [DW-1:0] quo_ff   [0:DW];
   logic [RW-1:0] rem_ff   [0:DW];
   logic [PW-1:0] pitch_ff [0:DW];
   logic          neg_ff   [0:DW];

   always_comb begin
      mag_ff[0]   = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
      quo_ff[0]   = '0;
      rem_ff[0]   = '0;
      pitch_ff[0] = pitch;
      neg_ff[0]   = dividend[DW-1];
   end

   for (genvar s = 0; s < DW; s++) begin : g_stage
      logic [RW:0]   trial;
      logic [RW:0]   diff;
      logic [DW-1:0] quo_in;
      always_comb begin
         trial  = {rem_ff[s], mag_ff[s][DW-1-s]};
         diff   = trial - {2'b00, pitch_ff[s]};
         quo_in = quo_ff[s];
         quo_in[DW-1-s] = !diff[RW];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            mag_ff[s+1]   <= mag_ff[s];
            pitch_ff[s+1] <= pitch_ff[s];
            neg_ff[s+1]   <= neg_ff[s];
            quo_ff[s+1]   <= quo_in;
            rem_ff[s+1]   <= diff[RW] ? trial[RW-1:0] : diff[RW-1:0];
         end
      end
   end

   logic nz;
   always_comb begin
      nz = (rem_ff[DW] != '0);
      if (neg_ff[DW] && nz) begin
         quotient  = ~quo_ff[DW];
         remainder = pitch_ff[DW] - rem_ff[DW][PW-1:0];
      end else if (neg_ff[DW]) begin
         quotient  = ~quo_ff[DW] + 1'b1;
         remainder = '0;
      end else begin
         quotient  = quo_ff[DW];
         remainder = rem_ff[DW][PW-1:0];
      end
   end

   logic unused_reset;
   assign unused_reset = reset;
endmodule

### sv/routing_track_grid_snap_top.sv
// Top level of the routing track grid snap block.
// Usage:
//  - req_ channel: one query transaction per handshake; tdata carries
//    window_start, window_stop, position, track_number (lowest first);
//    tuser carries round_mode then exact_required.
//  - rsp_ channel: one result transaction per query, in order; tdata carries
//    track_index, track_count, track_coordinate; tuser carries not_exact,
//    bad_window.
//  - csr_ APB port: offset at 0x0, pitch at 0x8; write only while idle.
// Throughput is one transaction per cycle while the receiver does not stall.
// A query passes the operand stage, the bit-per-stage dividers (three run side
// by side) and the fix-up stage into the output register.
// The whole pipeline advances only when the output register is free or
// being taken, so a stalled receiver freezes every stage and nothing is
// lost or repeated. Reset clears valid bits and the registers (offset 0,
// pitch 1); payload stages are not reset.
module routing_track_grid_snap_top #(
   parameter int COORD_WIDTH = 48
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // window_start, window_stop, position, track_number
   input  logic [4*COORD_WIDTH-1:0]   req_tdata,
   // round_mode[1:0], exact_required
   input  logic [2:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // track_index, track_count, track_coordinate, zero pad
   output logic [((3*COORD_WIDTH-1+7)/8)*8-1:0] rsp_tdata,
   // not_exact, bad_window
   output logic [1:0]                 rsp_tuser,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [3:0]                 csr_paddr,
   input  logic [63:0]                csr_pwdata,
   output logic [63:0]                csr_prdata,
   output logic                       csr_pready
);
   localparam int CW  = COORD_WIDTH;
   localparam int PW  = rtgs_pkg::PITCH_WIDTH;
   localparam int DW  = CW + 3;
   localparam int LAT = DW + 1;
   localparam int OW  = ((3*CW-1+7)/8)*8;
   localparam int HW  = CW / 2;

   logic signed [CW-1:0] offset_ff;
   logic [PW-1:0]        pitch_ff;
   logic [PW-1:0]        eff_pitch;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         pitch_ff  <= PW'(1);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[3] == rtgs_pkg::REG_TRACK_OFFSET) offset_ff <= csr_pwdata[CW-1:0];
         else pitch_ff <= csr_pwdata[PW-1:0];
      end
   end
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[3] == rtgs_pkg::REG_TRACK_OFFSET)
         csr_prdata = 64'(signed'(offset_ff));
      else
         csr_prdata[PW-1:0] = pitch_ff;
   end
   assign eff_pitch = (pitch_ff == '0) ? PW'(1) : pitch_ff;

   // Output register and global advance.
   logic advance;
   logic rsp_valid_ff;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;

   logic signed [CW-1:0] w_start, w_stop, w_pos, w_tnum;
   assign w_start = req_tdata[CW-1:0];
   assign w_stop  = req_tdata[2*CW-1:CW];
   assign w_pos   = req_tdata[3*CW-1:2*CW];
   assign w_tnum  = req_tdata[4*CW-1:3*CW];

   // Stage 0: form dividends and side values.
   logic                 v0_ff;
   logic signed [DW-1:0] d_pos_ff, d_start_ff, d_stop_ff;
   logic [1:0]           mode0_ff;
   logic                 exact0_ff, bad0_ff;
   logic signed [CW-1:0] tnum0_ff, base0_ff;
   logic [PW-1:0]        p0_ff;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (advance) v0_ff <= req_tvalid;
      if (advance) begin
         d_pos_ff   <= DW'(w_pos) - DW'(w_start) - DW'(offset_ff);
         d_start_ff <= DW'(w_start) - DW'(offset_ff);
         d_stop_ff  <= DW'(w_stop) - DW'(offset_ff);
         mode0_ff   <= req_tuser[1:0];
         exact0_ff  <= req_tuser[2];
         bad0_ff    <= w_start > w_stop;
         tnum0_ff   <= w_tnum;
         base0_ff   <= offset_ff + w_start;
         p0_ff      <= eff_pitch;
      end
   end

   // Dividers.
   logic signed [DW-1:0] q_pos, q_start, q_stop;
   logic [PW-1:0]        r_pos, r_start, r_stop;
   rtgs_div #(.DW(DW)) u_div_pos (.clock, .reset, .advance, .dividend(d_pos_ff),
      .pitch(p0_ff), .quotient(q_pos), .remainder(r_pos));
   rtgs_div #(.DW(DW)) u_div_start (.clock, .reset, .advance, .dividend(d_start_ff),
      .pitch(p0_ff), .quotient(q_start), .remainder(r_start));
   rtgs_div #(.DW(DW)) u_div_stop (.clock, .reset, .advance, .dividend(d_stop_ff),
      .pitch(p0_ff), .quotient(q_stop), .remainder(r_stop));

   // Side delay line.
   logic                 vd_ff     [1:LAT];
   logic [1:0]           moded_ff  [1:LAT];
   logic                 exactd_ff [1:LAT];
   logic                 badd_ff   [1:LAT];
   logic [PW-1:0]        pd_ff     [1:LAT];

   for (genvar s = 1; s <= LAT; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) vd_ff[s] <= 1'b0;
         else if (advance) vd_ff[s] <= (s == 1) ? v0_ff : vd_ff[s-1];
         if (advance) begin
            if (s == 1) begin
               moded_ff[s]  <= mode0_ff;
               exactd_ff[s] <= exact0_ff;
               badd_ff[s]   <= bad0_ff;
               pd_ff[s]     <= p0_ff;
            end else begin
               moded_ff[s]  <= moded_ff[s-1];
               exactd_ff[s] <= exactd_ff[s-1];
               badd_ff[s]   <= badd_ff[s-1];
               pd_ff[s]     <= pd_ff[s-1];
            end
         end
      end
   end

   // Coordinate: split the track number in halves, multiply each half by the
   // pitch in slot 1, add the shifted halves and the base in slot 2.
   logic [HW+PW-1:0]    plo1_ff;
   logic [CW-HW+PW-1:0] phi1_ff;
   logic [CW-1:0]       base1_ff;
   logic [CW-1:0]       coordd_ff [2:LAT];

   always_ff @(posedge clock) begin
      if (advance) begin
         plo1_ff      <= tnum0_ff[HW-1:0] * p0_ff;
         phi1_ff      <= tnum0_ff[CW-1:HW] * p0_ff;
         base1_ff     <= base0_ff;
         coordd_ff[2] <= CW'(plo1_ff) + (CW'(phi1_ff) << HW) + base1_ff;
      end
   end

   for (genvar s = 3; s <= LAT; s++) begin : g_coord
      always_ff @(posedge clock) begin
         if (advance) coordd_ff[s] <= coordd_ff[s-1];
      end
   end

   // Divider outputs line up with slot DW; finish in one stage.
   localparam int T = DW;
   logic [CW-1:0]  idx;
   logic signed [DW:0] qs, qe, n;
   logic [CW-2:0]  cnt;
   always_comb begin
      idx = q_pos[CW-1:0];
      unique case (rtgs_pkg::round_mode_type'(moded_ff[T]))
         rtgs_pkg::ROUND_UP, rtgs_pkg::ROUND_UP_ALT:
            if (r_pos != '0) idx = idx + 1'b1;
         rtgs_pkg::ROUND_NEAREST:
            if (r_pos > (pd_ff[T] >> 1)) idx = idx + 1'b1;
         default: ;
      endcase
      qs = (DW+1)'(q_start) + ((r_start != '0) ? 1 : 0);
      qe = (DW+1)'(q_stop) - ((r_stop == '0) ? 1 : 0);
      n  = qe - qs + 1;
      if (badd_ff[T] || n[DW]) cnt = '0;
      else if (n > (DW+1)'({(CW-1){1'b1}})) cnt = '1;
      else cnt = n[CW-2:0];
   end

   logic [OW-1:0] data_ff;
   logic [1:0]    user_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= vd_ff[T];
      if (advance) begin
         data_ff <= OW'({coordd_ff[T], cnt, idx});
         user_ff <= {badd_ff[T], exactd_ff[T] && (r_pos != '0)};
      end
   end
   assign rsp_tdata = data_ff;
   assign rsp_tuser = user_ff;

   logic unused_tail;
   assign unused_tail = vd_ff[LAT] ^ moded_ff[LAT][0] ^ exactd_ff[LAT] ^ badd_ff[LAT]
                      ^ pd_ff[LAT][0] ^ coordd_ff[LAT][0];
endmodule

### sim/tb_top.sv
// Self-checking testbench for the routing track grid snap block.
`timescale 1ns / 1ps

module tb_top;

   localparam int CW = 48;
   localparam int PW = rtgs_pkg::PITCH_WIDTH;
   localparam int LATENCY = CW + 5;
   localparam int DRAIN_CYCLES = LATENCY + 10;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic [3:0] ADDR_OFFSET = {rtgs_pkg::REG_TRACK_OFFSET, 3'b000};
   localparam logic [3:0] ADDR_PITCH = {rtgs_pkg::REG_TRACK_PITCH, 3'b000};
   localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-2:0] COUNT_MAX = {(CW-1){1'b1}};
   localparam int RANDOM_PER_PHASE = 320;

   // One grid query as carried by a request transaction.
   typedef struct {
      logic signed [CW-1:0] win_start;
      logic signed [CW-1:0] win_stop;
      logic signed [CW-1:0] pos;
      rtgs_pkg::round_mode_type mode;
      logic exact;
      logic signed [CW-1:0] track_num;
   } query_type;

   // One snap result as carried by a response transaction.
   typedef struct {
      logic [CW-1:0] index;
      logic [CW-2:0] count;
      logic [CW-1:0] coord;
      logic not_exact;
      logic bad_window;
   } snap_type;

   // A row of the directed table: a query and, where typed in, its result.
   typedef struct {
      query_type q;
      logic typed;
      snap_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [4*CW-1:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   // Local copy of the two grid registers.
   logic signed [CW-1:0] grid_offset = '0;
   logic [PW-1:0] grid_pitch = PW'(1);

   snap_type pending_snaps[$];
   int errors = 0;
   int queries_sent = 0;
   int snaps_checked = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   longint cycle = 0;
   row_type table_rows[$];

   always #1 clock = ~clock;

   routing_track_grid_snap_top #(.COORD_WIDTH(CW)) dut (.*);

   // Abort a hung run.
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle,
                  pending_snaps.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Floor division with a remainder in [0, pitch), on exact wide values.
   function automatic logic signed [127:0] floor_div(input logic signed [127:0] num,
                                                    input logic signed [127:0] den,
                                                    output logic signed [127:0] rem);
      logic signed [127:0] quo;
      quo = num / den;
      rem = num % den;
      if (rem < 0) begin
         rem = rem + den;
         quo = quo - 1;
      end
      return quo;
   endfunction

   // Compute the snap result of one query under the current registers.
   function automatic snap_type snap_query(input query_type q);
      snap_type s;
      logic [PW-1:0] pitch_eff;
      logic signed [127:0] den, rem, quo, qs, qe, rs, re, span;
      logic signed [127:0] w_start, w_stop, w_pos, w_off;
      pitch_eff = (grid_pitch == '0) ? PW'(1) : grid_pitch;
      den = $signed({97'b0, pitch_eff});
      w_start = q.win_start;
      w_stop = q.win_stop;
      w_pos = q.pos;
      w_off = grid_offset;
      quo = floor_div(w_pos - w_start - w_off, den, rem);
      case (q.mode)
         rtgs_pkg::ROUND_UP, rtgs_pkg::ROUND_UP_ALT: if (rem != 0) quo = quo + 1;
         rtgs_pkg::ROUND_NEAREST: if (rem > (den >>> 1)) quo = quo + 1;
         default: ;
      endcase
      s.index = quo[CW-1:0];
      s.not_exact = q.exact && (rem != 0);
      s.bad_window = q.win_start > q.win_stop;
      s.count = '0;
      if (!s.bad_window) begin
         qs = floor_div(w_start - w_off, den, rs);
         qe = floor_div(w_stop - w_off, den, re);
         if (rs != 0) qs = qs + 1;
         if (re == 0) qe = qe - 1;
         span = qe - qs + 1;
         if (span > $signed({81'b0, COUNT_MAX})) s.count = COUNT_MAX;
         else if (span > 0) s.count = span[CW-2:0];
      end
      s.coord = q.track_num * {{(CW-PW){1'b0}}, pitch_eff}
                + grid_offset + q.win_start;
      return s;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("mismatch at cycle %0d: %s got %h want %h", cycle, field, got, want);
   endtask

   // Check every response transaction against the oldest pending result.
   always @(posedge clock) begin
      snap_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_snaps.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[63:0], '0);
         end else begin
            want = pending_snaps.pop_front();
            snaps_checked++;
            if (rsp_tdata[47:0] !== want.index)
               report_mismatch("track_index", rsp_tdata[47:0], want.index);
            if (rsp_tdata[94:48] !== want.count)
               report_mismatch("track_count", rsp_tdata[94:48], want.count);
            if (rsp_tdata[142:95] !== want.coord)
               report_mismatch("track_coordinate", rsp_tdata[142:95], want.coord);
            if (rsp_tuser[0] !== want.not_exact)
               report_mismatch("not_exact", rsp_tuser[0], want.not_exact);
            if (rsp_tuser[1] !== want.bad_window)
               report_mismatch("bad_window", rsp_tuser[1], want.bad_window);
         end
      end
   end

   // Stall the receiver at random, redrawn each cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Write one grid register through the APB port: setup, then access.
   task automatic csr_write(input logic [3:0] addr, input logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_OFFSET) grid_offset = value[CW-1:0];
      else grid_pitch = value[PW-1:0];
   endtask

   // Drive one query and hold it until the transaction; keep tvalid high after.
   task automatic send_query(input query_type q, input logic use_typed,
                             input snap_type typed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {q.track_num, q.pos, q.win_stop, q.win_start};
      req_tuser <= {q.exact, q.mode};
      do @(posedge clock); while (!req_tready);
      pending_snaps.push_back(use_typed ? typed : snap_query(q));
      queries_sent++;
   endtask

   // Drop tvalid and let the pipeline empty, then wait out the drain period.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_snaps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] rand_coord();
      return CW'({$urandom, $urandom});
   endfunction

   // Mostly well-formed windows near the grid origin, some full-range noise.
   function automatic query_type rand_query();
      query_type q;
      int unsigned sel;
      sel = $urandom_range(99);
      q.mode = rtgs_pkg::round_mode_type'($urandom_range(3));
      q.exact = 1'($urandom_range(1));
      if (sel < 20) begin
         q.win_start = rand_coord();
         q.win_stop = rand_coord();
         q.pos = rand_coord();
         q.track_num = rand_coord();
      end else begin
         q.win_start = grid_offset + $signed(CW'($urandom_range(4000))) - 2000;
         q.win_stop = q.win_start + $signed(CW'($urandom_range(60000)))
                      - ((sel < 30) ? 3000 : 0);
         q.pos = q.win_start + $signed(CW'($urandom_range(60000)))
                 - $signed(CW'($urandom_range(2000)));
         q.track_num = (sel < 40) ? rand_coord()
                                  : $signed(CW'($urandom_range(200))) - 100;
         if (sel >= 95) begin
            q.win_start = COORD_MIN;
            q.win_stop = COORD_MAX;
         end
      end
      return q;
   endfunction

   function automatic row_type row(input logic signed [CW-1:0] s, e, p,
                                   input rtgs_pkg::round_mode_type m,
                                   input logic x, input logic signed [CW-1:0] t);
      row_type r;
      r.q = '{s, e, p, m, x, t};
      r.typed = 1'b0;
      r.want = '{'0, '0, '0, 1'b0, 1'b0};
      return r;
   endfunction

   initial begin
      logic [63:0] phase_offset[5];
      logic [63:0] phase_pitch[5];
      row_type r;
      // Directed table; typed results assume the reset grid (offset 0, pitch 1).
      r = row(0, 10, 5, rtgs_pkg::ROUND_DOWN, 1, 3);
      r.typed = 1; r.want = '{48'd5, 47'd10, 48'd3, 1'b0, 1'b0};
      table_rows.push_back(r);
      // Inverted window: count forced to zero.
      r = row(10, 0, 0, rtgs_pkg::ROUND_UP, 0, 0);
      r.typed = 1; r.want = '{-48'sd10, 47'd0, 48'd10, 1'b0, 1'b1};
      table_rows.push_back(r);
      // Widest window: index wraps, count saturates.
      r = row(COORD_MIN, COORD_MAX, COORD_MAX, rtgs_pkg::ROUND_NEAREST, 1, COORD_MAX);
      r.typed = 1; r.want = '{'1, COUNT_MAX, '1, 1'b0, 1'b0};
      table_rows.push_back(r);
      table_rows.push_back(row(COORD_MAX, COORD_MIN, COORD_MIN, rtgs_pkg::ROUND_UP_ALT,
                               1, COORD_MIN));
      table_rows.push_back(row(0, 0, 0, rtgs_pkg::ROUND_DOWN, 0, '1));
      table_rows.push_back(row(3, 33, 7, rtgs_pkg::ROUND_DOWN, 1, 2));
      table_rows.push_back(row(3, 33, 7, rtgs_pkg::ROUND_UP, 1, 2));
      table_rows.push_back(row(3, 33, 7, rtgs_pkg::ROUND_NEAREST, 0, 2));
      table_rows.push_back(row(3, 33, 9, rtgs_pkg::ROUND_NEAREST, 0, 2));
      table_rows.push_back(row(3, 33, 7, rtgs_pkg::ROUND_UP_ALT, 0, -5));
      table_rows.push_back(row(-25, -6, -40, rtgs_pkg::ROUND_NEAREST, 1, -1));
      table_rows.push_back(row(COORD_MAX, COORD_MAX, COORD_MIN, rtgs_pkg::ROUND_DOWN,
                               1, COORD_MAX));

      phase_offset = '{0, 64'(COORD_MIN), 64'(COORD_MAX), 64'(-48'sd777), 0};
      phase_pitch = '{0, 64'h7FFF_FFFF, 1, 7, 1000};
      phase_offset[4] = {$urandom, $urandom};
      phase_pitch[4] = $urandom_range(32'h7FFF_FFFF, 2);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the table under the reset grid, then under an offset grid.
      foreach (table_rows[i]) send_query(table_rows[i].q, table_rows[i].typed,
                                         table_rows[i].want);
      drain();
      csr_write(ADDR_OFFSET, 64'd3);
      csr_write(ADDR_PITCH, 64'd10);
      foreach (table_rows[i]) send_query(table_rows[i].q, 1'b0, table_rows[i].want);
      drain();

      // Random phases, each under its own grid; phases 0-1 and 2-3 share an idle pattern.
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(ADDR_OFFSET, phase_offset[ph]);
         csr_write(ADDR_PITCH, phase_pitch[ph]);
         send_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 70 : 0;
         recv_stall_pct = (ph < 2) ? 70 : (ph < 4) ? 24 : 0;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Hold off mid-phase until every pending result has come back.
            if (ph == 2 && n == RANDOM_PER_PHASE / 2) begin
               req_tvalid <= 1'b0;
               while (pending_snaps.size() != 0) @(posedge clock);
            end
            send_query(rand_query(), 1'b0, table_rows[0].want);
         end
         drain();
      end

      if (pending_snaps.size() != 0) begin
         report_mismatch("results never arrived", 64'(pending_snaps.size()), '0);
      end
      $display("run covered %0d queries over seven grid settings, %0d results checked",
               queries_sent, snaps_checked);
      $display("grids included zero, minimum and maximum pitch and both offset extremes");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d errors", errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
sv/rtgs_pkg.sv
sv/rtgs_div.sv
sv/routing_track_grid_snap_top.sv
sim/tb_top.sv
